FILE: rtl/core/rhcm_pkg.sv
// Shared constants for the RGB histogram colour matcher.
// No dependencies; imported by rgb_histogram_color_match.
`default_nettype none

package rhcm_pkg;

    localparam int BIN_COUNT      = 256;
    localparam int BIN_BITS       = $clog2(BIN_COUNT);
    localparam int CHANNEL_COUNT  = 3;
    localparam int COUNT_BITS_DEF = 24;

    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam int THR_W = 7;
    localparam logic [THR_W-1:0] THR_RESET = 7'd50;

    localparam int PERCENT_SCALE = 100;
    localparam int PCT_BITS      = $clog2(PERCENT_SCALE);

    localparam int SIZE_W = 26;
    localparam int OUT_W  = 24;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

endpackage

`default_nettype wire

FILE: rtl/core/rhcm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rhcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_histogram_color_match.sv
// Top level of the RGB histogram colour matcher.
// Depends on rhcm_pkg and rhcm_ram.
`default_nettype none

// Usage
//   Command channel: an item transfers at a rising edge with start high and busy low.
//   func selects clear, pixel or query; func 3 is taken and ignored.
//   Clear: busy stays low; all bins read as zero afterwards.
//   Pixel: busy until its rows are updated; no new command is taken meanwhile. Each of up to three
//   distinct bin rows is read, incremented (saturating) and written back.
//   Query: busy until the result is out. All bins are swept through the single read port
//   of the bin memory, one row per cycle, then the threshold product and the comparison
//   follow in ST_MUL and ST_CMP. done pulses for one cycle as busy falls, carrying
//   close_match and the three window sums.
//   Throughput is set by the bin memory port: one row access per cycle.
//   Results cannot be stalled; done is a one-cycle strobe.
//   threshold_we writes threshold_percent; write it only while busy is low.
//   Reset: threshold goes to 50, all bins read as zero (row valid flags cleared),
//   no warm-up is needed.
module rgb_histogram_color_match #(
    parameter int COUNT_BITS = rhcm_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rhcm_pkg::FUNC_W-1:0]   func,
    input  logic [rhcm_pkg::BIN_BITS-1:0] red,
    input  logic [rhcm_pkg::BIN_BITS-1:0] green,
    input  logic [rhcm_pkg::BIN_BITS-1:0] blue,
    input  logic [rhcm_pkg::BIN_BITS-1:0] deviation,
    input  logic [rhcm_pkg::SIZE_W-1:0]   image_size,
    input  logic                          threshold_we,
    input  logic [rhcm_pkg::THR_W-1:0]    threshold_percent,
    output logic                          done,
    output logic                          close_match,
    output logic [rhcm_pkg::OUT_W-1:0]    red_window_sum,
    output logic [rhcm_pkg::OUT_W-1:0]    green_window_sum,
    output logic [rhcm_pkg::OUT_W-1:0]    blue_window_sum
);

    import rhcm_pkg::*;

    localparam int ROW_W    = CHANNEL_COUNT * COUNT_BITS;
    localparam int SUM_W    = COUNT_BITS + BIN_BITS;
    localparam int SCALED_W = SUM_W + PCT_BITS;
    localparam int NEED_W   = THR_W + SIZE_W;
    localparam int CMP_W    = (SCALED_W > NEED_W) ? SCALED_W : NEED_W;
    localparam int SAT_W    = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int DIV_SHIFT = SIZE_W + 1;
    localparam int PROD_W    = SIZE_W + DIV_SHIFT;
    localparam int CH_W     = $clog2(CHANNEL_COUNT);
    localparam logic [CH_W-1:0]     STEP_LAST = CH_W'(CHANNEL_COUNT - 1);
    localparam logic [BIN_BITS-1:0] BIN_MAX   = BIN_BITS'(BIN_COUNT - 1);
    // ceil(2^DIV_SHIFT / 3): exact quotient over the whole image_size range
    localparam logic [SIZE_W-1:0]   DIV_RECIP = SIZE_W'(((64'd1 << DIV_SHIFT)
        + 64'(CHANNEL_COUNT - 1)) / 64'(CHANNEL_COUNT));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_SWEEP,
        ST_MUL,
        ST_CMP
    } state_t;

    // control
    state_t                state_reg;
    logic [CH_W-1:0]       step_reg;
    logic [BIN_BITS:0]     cnt_reg;
    logic                  rd_pend_reg;
    logic [BIN_COUNT-1:0]  valid_reg;
    logic [THR_W-1:0]      thr_reg;
    logic                  done_reg;
    logic                  match_reg;
    logic [OUT_W-1:0]      out_sum_reg [CHANNEL_COUNT];

    // payload
    logic [BIN_BITS-1:0]   pix_reg     [CHANNEL_COUNT];
    logic [BIN_BITS-1:0]   lo_reg      [CHANNEL_COUNT];
    logic [BIN_BITS-1:0]   hi_reg      [CHANNEL_COUNT];
    logic [SUM_W-1:0]      sum_reg     [CHANNEL_COUNT];
    logic [SCALED_W-1:0]   scaled_reg  [CHANNEL_COUNT];
    logic [NEED_W-1:0]     need_reg;
    logic [SIZE_W-1:0]     quo_reg;
    logic                  size_zero_reg;
    logic [BIN_BITS-1:0]   rd_addr_reg;

    // memory port
    logic                  re;
    logic [BIN_BITS-1:0]   raddr;
    logic [ROW_W-1:0]      rdata;
    logic                  we;
    logic [BIN_BITS-1:0]   waddr;
    logic [ROW_W-1:0]      wdata;

    logic [ROW_W-1:0]      row_data;
    logic [BIN_BITS-1:0]   in_byte     [CHANNEL_COUNT];
    logic [BIN_BITS-1:0]   win_lo      [CHANNEL_COUNT];
    logic [BIN_BITS-1:0]   win_hi      [CHANNEL_COUNT];
    logic                  owner;
    logic [PROD_W-1:0]     quo_prod;
    logic                  match_now;
    logic [OUT_W-1:0]      sat_sum     [CHANNEL_COUNT];

    assign in_byte[0] = red;
    assign in_byte[1] = green;
    assign in_byte[2] = blue;

    rhcm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // rows never written since the last clear read as zero
    assign row_data = valid_reg[rd_addr_reg] ? rdata : '0;

    always_comb
    begin
        re    = 1'b0;
        raddr = red;
        unique case (state_reg)
            ST_IDLE:
            begin
                re    = start && (func == FUNC_PIXEL);
                raddr = red;
            end
            ST_PIX:
            begin
                re = (step_reg != STEP_LAST);
                if (step_reg != STEP_LAST)
                begin
                    raddr = pix_reg[step_reg + 1'b1];
                end
            end
            ST_SWEEP:
            begin
                re    = !cnt_reg[BIN_BITS];
                raddr = cnt_reg[BIN_BITS-1:0];
            end
            ST_MUL, ST_CMP:
            begin
                re = 1'b0;
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    // Pixel update: the first channel to hit a row owns it and bumps every lane
    // that shares it; later channels on the same row skip their write.
    always_comb
    begin
        logic [COUNT_BITS-1:0] lane;
        waddr = pix_reg[step_reg];
        owner = 1'b1;
        wdata = row_data;
        for (int j = 0; j < CHANNEL_COUNT; j++)
        begin
            if ((CH_W'(j) < step_reg) && (pix_reg[j] == waddr))
            begin
                owner = 1'b0;
            end
        end
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            lane = row_data[c*COUNT_BITS +: COUNT_BITS];
            if ((pix_reg[c] == waddr) && !(&lane))
            begin
                lane = lane + 1'b1;
            end
            wdata[c*COUNT_BITS +: COUNT_BITS] = lane;
        end
        we = (state_reg == ST_PIX) && owner;
    end

    // window bounds, clamped to the bin range
    always_comb
    begin
        logic [BIN_BITS:0] upper;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            upper     = {1'b0, in_byte[c]} + {1'b0, deviation};
            win_lo[c] = (in_byte[c] >= deviation) ? (in_byte[c] - deviation) : '0;
            win_hi[c] = (upper < {1'b0, BIN_MAX}) ? upper[BIN_BITS-1:0] : BIN_MAX;
        end
    end

    // image_size / 3 by reciprocal multiplication
    assign quo_prod = PROD_W'(quo_reg) * PROD_W'(DIV_RECIP);

    always_comb
    begin
        logic [SAT_W-1:0] ext;
        match_now = !size_zero_reg;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            if (CMP_W'(scaled_reg[c]) < CMP_W'(need_reg))
            begin
                match_now = 1'b0;
            end
            ext        = SAT_W'(sum_reg[c]);
            sat_sum[c] = (ext > SAT_W'(OUT_MAX)) ? OUT_MAX : ext[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            valid_reg   <= '0;
            thr_reg     <= THR_RESET;
            done_reg    <= 1'b0;
            match_reg   <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                out_sum_reg[c] <= '0;
            end
        end
        else
        begin
            done_reg    <= 1'b0;
            rd_pend_reg <= re;
            if (threshold_we)
            begin
                thr_reg <= threshold_percent;
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        unique case (func)
                            FUNC_CLEAR:
                            begin
                                valid_reg <= '0;
                            end
                            FUNC_PIXEL:
                            begin
                                state_reg <= ST_PIX;
                                step_reg  <= '0;
                            end
                            FUNC_QUERY:
                            begin
                                state_reg <= ST_SWEEP;
                                cnt_reg   <= '0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PIX:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SWEEP:
                begin
                    if (!cnt_reg[BIN_BITS])
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                    match_reg <= match_now;
                    for (int c = 0; c < CHANNEL_COUNT; c++)
                    begin
                        out_sum_reg[c] <= sat_sum[c];
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_addr_reg <= raddr;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                for (int c = 0; c < CHANNEL_COUNT; c++)
                begin
                    pix_reg[c] <= in_byte[c];
                    lo_reg[c]  <= win_lo[c];
                    hi_reg[c]  <= win_hi[c];
                    sum_reg[c] <= '0;
                end
                quo_reg       <= image_size;
                size_zero_reg <= (image_size == '0);
            end
            ST_SWEEP:
            begin
                if (rd_pend_reg)
                begin
                    for (int c = 0; c < CHANNEL_COUNT; c++)
                    begin
                        if ((rd_addr_reg >= lo_reg[c]) && (rd_addr_reg <= hi_reg[c]))
                        begin
                            sum_reg[c] <= sum_reg[c]
                                + SUM_W'(row_data[c*COUNT_BITS +: COUNT_BITS]);
                        end
                    end
                end
                // replace the size by its third on the first sweep cycle
                if (cnt_reg == '0)
                begin
                    quo_reg <= quo_prod[PROD_W-1:DIV_SHIFT];
                end
            end
            ST_MUL:
            begin
                need_reg <= NEED_W'(thr_reg) * NEED_W'(quo_reg);
                for (int c = 0; c < CHANNEL_COUNT; c++)
                begin
                    scaled_reg[c] <= SCALED_W'(sum_reg[c]) * SCALED_W'(PERCENT_SCALE);
                end
            end
            ST_PIX, ST_CMP:
            begin
                need_reg <= need_reg;
            end
            default:
            begin
                need_reg <= need_reg;
            end
        endcase
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign close_match      = match_reg;
    assign red_window_sum   = out_sum_reg[0];
    assign green_window_sum = out_sum_reg[1];
    assign blue_window_sum  = out_sum_reg[2];

    // the read pipeline is empty when the sweep hands over to the multiply
    a_sweep_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> !rd_pend_reg)
        else $error("bin read still pending after the sweep");

    // a pixel never writes the same row on consecutive cycles
    a_row_once: assert property (@(posedge clk) disable iff (!rst_n)
        (we && $past(we)) |-> (waddr != $past(waddr)))
        else $error("bin row written twice for one pixel");

    // a written row reads as valid from then on
    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> valid_reg[$past(waddr)])
        else $error("row valid flag not set after write");

    // a result only follows the compare cycle, with the block back to idle
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(state_reg) == ST_CMP))
        else $error("result strobe without a finished query");

    // a taken query always occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_QUERY) |=> (state_reg == ST_SWEEP && cnt_reg == '0))
        else $error("query transfer did not start the sweep");

endmodule

`default_nettype wire
